// ===== rtl/irhm_pkg.sv =====
// Shared types and constants for the ID relabel hash map.
package irhm_pkg;

  localparam int KEY_W      = 63;
  localparam int INDEX_W    = 12;
  localparam int COUNT_W    = 13;
  localparam int CMD_W      = 2;
  localparam int CAP_W      = 4;

  localparam int TABLE_LOG2_DEFAULT = 12;
  localparam int MAX_PROBES_DEFAULT = 32;

  localparam logic [CAP_W-1:0]   CAP_RESET   = 4'd12;
  localparam logic [COUNT_W-1:0] INDEX_LIMIT = 13'd4096;

  localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
  localparam logic [CMD_W-1:0] CMD_LOOKUP = 2'd1;
  localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd2;
  localparam logic [CMD_W-1:0] CMD_NOP    = 2'd3;

  typedef struct packed {
    logic               used;
    logic [KEY_W-1:0]   key;
    logic [INDEX_W-1:0] idx;
  } slot_entry_t;

endpackage

// ===== rtl/id_relabel_hash_map_unit.sv =====
// Top level: quadratic-probing hash map that assigns compact indices to keys.
// Insert/lookup: done strobes once the read of the last of P probes is resolved
//   (one memory read per cycle); the next command is taken in the done cycle.
// Clear: a sweep of all 2^TABLE_LOG2 slots, one slot per cycle, then done.
// Reset: starts the same sweep with busy high and no done; register gets 12.
// Results are shown for one cycle on done; the receiver cannot stall.
module id_relabel_hash_map_unit
  import irhm_pkg::*;
#(
  parameter int TABLE_LOG2 = TABLE_LOG2_DEFAULT,
  parameter int MAX_PROBES = MAX_PROBES_DEFAULT
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               capacity_log2_we,
  input  logic [CAP_W-1:0]   capacity_log2,
  input  logic               start,
  output logic               busy,
  input  logic [CMD_W-1:0]   command,
  input  logic [KEY_W-1:0]   key,
  output logic               done,
  output logic [INDEX_W-1:0] index,
  output logic               is_new,
  output logic               found,
  output logic               table_full,
  output logic [COUNT_W-1:0] unique_count
);

  localparam int TL = TABLE_LOG2;
  localparam int PW = $clog2(MAX_PROBES + 1);

  localparam logic [1:0] S_CLEAR = 2'd0;
  localparam logic [1:0] S_IDLE  = 2'd1;
  localparam logic [1:0] S_PROBE = 2'd2;

  logic [1:0]         state;
  logic [CAP_W-1:0]   cap;
  logic [COUNT_W-1:0] count;
  logic [TL-1:0]      sweep_addr;
  logic               clear_reply;
  logic [CMD_W-1:0]   cmd_q;
  logic [KEY_W-1:0]   key_q;
  logic [TL-1:0]      pos;
  logic [TL-1:0]      sq;
  logic [TL-1:0]      odd;
  logic [PW-1:0]      probe_cnt;

  logic [CAP_W-1:0]   cap_eff;
  logic [TL-1:0]      mask;
  logic [TL-1:0]      home;
  logic [TL-1:0]      pos_next;

  logic               ram_we;
  logic [TL-1:0]      ram_addr;
  slot_entry_t        ram_wdata;
  slot_entry_t        ram_rdata;

  irhm_slot_ram #(
    .TABLE_LOG2(TABLE_LOG2)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .addr (ram_addr),
    .wdata(ram_wdata),
    .rdata(ram_rdata)
  );

  assign busy = (state != S_IDLE);

  always_comb begin
    if (cap < CAP_W'(1)) begin
      cap_eff = CAP_W'(1);
    end else if (32'(cap) > TL) begin
      cap_eff = CAP_W'(TL);
    end else begin
      cap_eff = cap;
    end
    for (int i = 0; i < TL; i++) begin
      mask[i] = (i < 32'(cap_eff));
    end
  end

  assign home     = key[TL-1:0] & mask;
  assign pos_next = (pos + sq) & mask;

  logic hit;
  logic last_probe;
  assign hit        = ram_rdata.used && (ram_rdata.key == key_q);
  assign last_probe = (probe_cnt == PW'(MAX_PROBES - 1));

  always_comb begin
    ram_we    = 1'b0;
    ram_addr  = pos_next;
    ram_wdata = '0;
    case (state)
      S_CLEAR: begin
        ram_we   = 1'b1;
        ram_addr = sweep_addr;
      end
      S_IDLE: begin
        ram_addr = home;
      end
      S_PROBE: begin
        if (!ram_rdata.used) begin
          ram_addr = pos;
          if (cmd_q == CMD_INSERT && count != INDEX_LIMIT) begin
            ram_we          = 1'b1;
            ram_wdata.used  = 1'b1;
            ram_wdata.key   = key_q;
            ram_wdata.idx   = count[INDEX_W-1:0];
          end
        end
      end
      default: begin
        ram_addr = pos_next;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_CLEAR;
      cap         <= CAP_RESET;
      count       <= '0;
      sweep_addr  <= '0;
      clear_reply <= 1'b0;
      done        <= 1'b0;
    end else begin
      done <= 1'b0;
      if (capacity_log2_we) begin
        cap <= capacity_log2;
      end
      case (state)
        S_CLEAR: begin
          sweep_addr <= sweep_addr + TL'(1);
          if (sweep_addr == {TL{1'b1}}) begin
            state        <= S_IDLE;
            done         <= clear_reply;
            index        <= '0;
            is_new       <= 1'b0;
            found        <= 1'b0;
            table_full   <= 1'b0;
            unique_count <= count;
          end
        end
        S_IDLE: begin
          if (start) begin
            cmd_q     <= command;
            key_q     <= key;
            pos       <= home;
            sq        <= TL'(1);
            odd       <= TL'(3);
            probe_cnt <= '0;
            case (command)
              CMD_INSERT, CMD_LOOKUP: begin
                state <= S_PROBE;
              end
              CMD_CLEAR: begin
                state       <= S_CLEAR;
                sweep_addr  <= '0;
                clear_reply <= 1'b1;
                count       <= '0;
              end
              default: begin
                done         <= 1'b1;
                index        <= '0;
                is_new       <= 1'b0;
                found        <= 1'b0;
                table_full   <= 1'b0;
                unique_count <= count;
              end
            endcase
          end
        end
        S_PROBE: begin
          index        <= '0;
          is_new       <= 1'b0;
          found        <= 1'b0;
          table_full   <= 1'b0;
          unique_count <= count;
          if (!ram_rdata.used) begin
            state <= S_IDLE;
            done  <= 1'b1;
            if (cmd_q == CMD_INSERT) begin
              if (count != INDEX_LIMIT) begin
                index        <= count[INDEX_W-1:0];
                is_new       <= 1'b1;
                found        <= 1'b1;
                count        <= count + COUNT_W'(1);
                unique_count <= count + COUNT_W'(1);
              end else begin
                table_full <= 1'b1;
              end
            end
          end else if (hit) begin
            state <= S_IDLE;
            done  <= 1'b1;
            index <= ram_rdata.idx;
            found <= 1'b1;
          end else if (last_probe) begin
            state      <= S_IDLE;
            done       <= 1'b1;
            table_full <= 1'b1;
          end else begin
            pos       <= pos_next;
            sq        <= sq + odd;
            odd       <= odd + TL'(2);
            probe_cnt <= probe_cnt + PW'(1);
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== rtl/irhm_slot_ram.sv =====
// Single-port slot memory with registered read data.
module irhm_slot_ram
  import irhm_pkg::*;
#(
  parameter int TABLE_LOG2 = TABLE_LOG2_DEFAULT
) (
  input  logic                  clk,
  input  logic                  we,
  input  logic [TABLE_LOG2-1:0] addr,
  input  slot_entry_t           wdata,
  output slot_entry_t           rdata
);

  localparam int SLOTS = 1 << TABLE_LOG2;

  slot_entry_t mem [SLOTS];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

// ===== tb/sv/id_relabel_hash_map_unit_tb.sv =====
// Self-checking testbench for the ID relabel hash map: directed and random commands.
`timescale 1ns / 100ps

module id_relabel_hash_map_unit_tb
  import irhm_pkg::*;
();

  typedef struct packed {
    logic [INDEX_W-1:0] index;
    logic               is_new;
    logic               found;
    logic               table_full;
    logic [COUNT_W-1:0] unique_count;
  } map_result_t;

  class relabel_shadow;
    bit                 used_slot [1 << TABLE_LOG2_DEFAULT];
    logic [KEY_W-1:0]   key_at    [1 << TABLE_LOG2_DEFAULT];
    logic [INDEX_W-1:0] index_at  [1 << TABLE_LOG2_DEFAULT];
    int                 stored;
    logic [CAP_W-1:0]   cap_reg;
    map_result_t        pending_results [$];
    int                 errors;

    function new();
      foreach (used_slot[i]) used_slot[i] = 1'b0;
      stored  = 0;
      cap_reg = CAP_RESET;
      errors  = 0;
    endfunction

    function void set_capacity(logic [CAP_W-1:0] v);
      cap_reg = v;
    endfunction

    function int pending();
      return pending_results.size();
    endfunction

    function void note_command(logic [CMD_W-1:0] cmd, logic [KEY_W-1:0] k);
      map_result_t r;
      int          c;
      int          mask;
      int          pos;
      int          delta;
      int          p;
      bit          settled;
      r = '0;
      if (cmd == CMD_CLEAR) begin
        foreach (used_slot[i]) used_slot[i] = 1'b0;
        stored = 0;
      end else if (cmd == CMD_INSERT || cmd == CMD_LOOKUP) begin
        c = cap_reg;
        if (c < 1) c = 1;
        if (c > TABLE_LOG2_DEFAULT) c = TABLE_LOG2_DEFAULT;
        mask    = (1 << c) - 1;
        pos     = int'(k[INDEX_W-1:0]) & mask;
        delta   = 1;
        settled = 1'b0;
        for (p = 0; p < MAX_PROBES_DEFAULT && !settled; p++) begin
          if (!used_slot[pos]) begin
            settled = 1'b1;
            if (cmd == CMD_INSERT) begin
              if (stored < int'(INDEX_LIMIT)) begin
                used_slot[pos] = 1'b1;
                key_at[pos]    = k;
                index_at[pos]  = INDEX_W'(stored);
                r.index        = INDEX_W'(stored);
                r.is_new       = 1'b1;
                r.found        = 1'b1;
                stored++;
              end else begin
                r.table_full = 1'b1;
              end
            end
          end else if (key_at[pos] == k) begin
            settled = 1'b1;
            r.index = index_at[pos];
            r.found = 1'b1;
          end else begin
            pos = (pos + delta * delta) & mask;
            delta++;
          end
        end
        if (!settled) r.table_full = 1'b1;
      end
      r.unique_count = COUNT_W'(stored);
      pending_results.push_back(r);
    endfunction

    function void check_result(map_result_t got);
      map_result_t want;
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result: index %0d new %0b found %0b full %0b count %0d",
                 $time, got.index, got.is_new, got.found, got.table_full, got.unique_count);
        errors++;
        return;
      end
      want = pending_results.pop_front();
      if (got !== want) begin
        $display("%0t: index exp %0d got %0d, is_new exp %0b got %0b, found exp %0b got %0b",
                 $time, want.index, got.index, want.is_new, got.is_new, want.found, got.found);
        $display("%0t: table_full exp %0b got %0b, unique_count exp %0d got %0d",
                 $time, want.table_full, got.table_full, want.unique_count, got.unique_count);
        errors++;
      end
    endfunction
  endclass

  logic               clk;
  logic               rst;
  logic               capacity_log2_we;
  logic [CAP_W-1:0]   capacity_log2;
  logic               start;
  logic               busy;
  logic [CMD_W-1:0]   command;
  logic [KEY_W-1:0]   key;
  logic               done;
  logic [INDEX_W-1:0] index;
  logic               is_new;
  logic               found;
  logic               table_full;
  logic [COUNT_W-1:0] unique_count;

  relabel_shadow    shadow = new();
  bit               idle_on;
  logic [KEY_W-1:0] key_pool [$];
  logic [KEY_W-1:0] last_key;
  logic [CAP_W-1:0] phase_caps [8] = '{4'd12, 4'd3, 4'd0, 4'd15, 4'd6, 4'd1, 4'd9, 4'd4};

  id_relabel_hash_map_unit u_top (
    .clk              (clk),
    .rst              (rst),
    .capacity_log2_we (capacity_log2_we),
    .capacity_log2    (capacity_log2),
    .start            (start),
    .busy             (busy),
    .command          (command),
    .key              (key),
    .done             (done),
    .index            (index),
    .is_new           (is_new),
    .found            (found),
    .table_full       (table_full),
    .unique_count     (unique_count)
  );

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  always @(posedge clk) begin
    if (!rst && done) begin
      shadow.check_result({index, is_new, found, table_full, unique_count});
    end
  end

  function automatic logic [KEY_W-1:0] rand_wide();
    logic [63:0] w;
    w = {$urandom(), $urandom()};
    return w[KEY_W-1:0];
  endfunction

  function automatic logic [KEY_W-1:0] rand_key();
    logic [KEY_W-1:0] w;
    w = rand_wide();
    case ($urandom_range(3))
      0: return w;
      1: return KEY_W'($urandom_range(255));
      2: return {KEY_W{1'b1}} ^ KEY_W'($urandom_range(255));
      default: return {w[KEY_W-1:INDEX_W], INDEX_W'($urandom_range(15))};
    endcase
  endfunction

  // hold start high across back-to-back transfers; drop it only for idle cycles
  task automatic send_item(input logic [CMD_W-1:0] cmd, input logic [KEY_W-1:0] k);
    while (idle_on && $urandom_range(99) < 36) begin
      start <= 1'b0;
      @(negedge clk);
    end
    start   <= 1'b1;
    command <= cmd;
    key     <= k;
    @(posedge clk);
    while (busy) @(posedge clk);
    shadow.note_command(cmd, k);
    @(negedge clk);
  endtask

  task automatic drain();
    start <= 1'b0;
    @(negedge clk);
    while (shadow.pending() != 0) @(negedge clk);
  endtask

  task automatic write_capacity(input logic [CAP_W-1:0] v);
    while (busy) @(negedge clk);
    capacity_log2_we <= 1'b1;
    capacity_log2    <= v;
    @(negedge clk);
    capacity_log2_we <= 1'b0;
    shadow.set_capacity(v);
  endtask

  initial begin
    #4000000;
    $display("id_relabel_hash_map_unit_tb NOT OK");
    $finish;
  end

  initial begin
    rst              = 1'b1;
    capacity_log2_we = 1'b0;
    capacity_log2    = CAP_RESET;
    start            = 1'b0;
    command          = CMD_NOP;
    key              = '0;
    idle_on          = 1'b1;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    write_capacity(CAP_RESET);
    send_item(CMD_INSERT, '0);
    send_item(CMD_INSERT, {KEY_W{1'b1}});
    send_item(CMD_INSERT, '0);
    send_item(CMD_LOOKUP, {KEY_W{1'b1}});
    send_item(CMD_LOOKUP, KEY_W'(5));
    send_item(CMD_NOP, KEY_W'({(KEY_W+1)/2{2'b10}}));
    send_item(CMD_INSERT, KEY_W'(4096));
    send_item(CMD_LOOKUP, KEY_W'(4096));
    send_item(CMD_INSERT, KEY_W'(8192));
    send_item(CMD_CLEAR, '0);
    send_item(CMD_LOOKUP, '0);
    drain();

    write_capacity(4'd1);
    send_item(CMD_INSERT, KEY_W'(0));
    send_item(CMD_INSERT, KEY_W'(1));
    send_item(CMD_INSERT, KEY_W'(2));
    send_item(CMD_LOOKUP, KEY_W'(3));
    send_item(CMD_LOOKUP, KEY_W'(1));
    drain();
    write_capacity(4'd0);
    send_item(CMD_INSERT, KEY_W'(5));
    drain();
    write_capacity(4'd15);
    send_item(CMD_LOOKUP, KEY_W'(1));
    send_item(CMD_LOOKUP, KEY_W'(4098));
    send_item(CMD_INSERT, KEY_W'(2));
    send_item(CMD_CLEAR, '0);
    drain();

    // insert keys with distinct home positions, no idle cycles
    write_capacity(4'd12);
    idle_on = 1'b0;
    for (int i = 0; i < 128; i++) begin
      last_key = rand_wide();
      last_key[INDEX_W-1:0] = INDEX_W'(i);
      send_item(CMD_INSERT, last_key);
    end
    send_item(CMD_LOOKUP, last_key);
    send_item(CMD_INSERT, last_key);
    send_item(CMD_INSERT, rand_key());
    send_item(CMD_LOOKUP, rand_key());
    send_item(CMD_CLEAR, '0);
    idle_on = 1'b1;

    foreach (phase_caps[ph]) begin
      drain();
      write_capacity(phase_caps[ph]);
      key_pool.delete();
      repeat ($urandom_range(8, 64)) key_pool.push_back(rand_key());
      if ($urandom_range(1) == 1) send_item(CMD_CLEAR, rand_wide());
      repeat (80) begin
        int unsigned pick;
        logic [KEY_W-1:0] k;
        pick = $urandom_range(99);
        if ($urandom_range(99) < 65) k = key_pool[$urandom_range(key_pool.size() - 1)];
        else k = rand_key();
        if (pick < 2) send_item(CMD_CLEAR, k);
        else if (pick < 5) send_item(CMD_NOP, k);
        else if (pick < 58) send_item(CMD_INSERT, k);
        else send_item(CMD_LOOKUP, k);
      end
    end

    drain();
    repeat (40) @(posedge clk);
    if (shadow.errors == 0) begin
      $display("id_relabel_hash_map_unit_tb OK");
    end else begin
      $display("id_relabel_hash_map_unit_tb NOT OK");
    end
    $finish;
  end

endmodule
